FILE: design/tbeh_pkg.sv
// Package for the time-binned energy histogram unit.
// Holds field widths, reset values, command and register codes and shared types.
// No dependencies; every other design file refers to it by scoped names.
package tbeh_pkg;

  localparam int unsigned NumBinsDef = 400;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned StepW      = 16;
  localparam int unsigned EnergyW    = 24;
  localparam int unsigned AccW       = 40;
  localparam int unsigned BinNumW    = 9;
  localparam int unsigned CmdW       = 2;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned InDataW    = 56;
  localparam int unsigned OutDataW   = 56;

  localparam logic [TimeW-1:0] TimeStartRst = 32'd1000;
  localparam logic [StepW-1:0] BinStepRst   = 16'd10;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIME_START = 2'd0,
    CFG_BIN_STEP   = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic             start;
    logic [TimeW-1:0] dividend;
    logic [StepW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [TimeW-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: design/time_binned_energy_histogram_unit.sv
// Top level of the time-binned energy histogram unit.
// Add and query pass through acceptance in ST_IDLE, the bit-serial divider in ST_DIV, then
// the bin memory read and update in ST_READ and ST_UPDATE. A time before the start skips the divider.
// A clear command sweeps the bin memory one entry per cycle, NUM_BINS entries in all.
// After reset the same sweep runs before the first item is taken.
// Configuration writes are taken in every cycle; uses tbeh_pkg and tbeh_div.
module time_binned_energy_histogram_unit #(
  parameter int unsigned NUM_BINS = tbeh_pkg::NumBinsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Fields from bit 0: time_stamp[31:0], energy[55:32].
  input  logic [tbeh_pkg::InDataW-1:0]    s_axis_tdata,
  // Fields from bit 0: command[1:0].
  input  logic [tbeh_pkg::CmdW-1:0]       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Fields from bit 0: bin_energy[39:0], bin_number[48:40], zero padding[55:49].
  output logic [tbeh_pkg::OutDataW-1:0]   m_axis_tdata,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tbeh_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [tbeh_pkg::TimeW-1:0]      cfg_data_i
);

  localparam int unsigned BinW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam logic [BinW-1:0] LastBin = BinW'(NUM_BINS - 1);
  localparam int unsigned AccW = tbeh_pkg::AccW;
  localparam int unsigned TimeW = tbeh_pkg::TimeW;
  localparam int unsigned StepW = tbeh_pkg::StepW;
  localparam int unsigned EnergyW = tbeh_pkg::EnergyW;
  localparam int unsigned BinNumW = tbeh_pkg::BinNumW;

  tbeh_pkg::state_e state_q, state_d;
  tbeh_pkg::cmd_e   cmd_q, cmd_d;
  logic [BinW-1:0]    clr_addr_q, clr_addr_d;
  logic [BinW-1:0]    bin_q, bin_d;
  logic [EnergyW-1:0] energy_q, energy_d;
  logic [TimeW-1:0]   time_start_q;
  logic [StepW-1:0]   bin_step_q;
  logic               m_valid_q, m_valid_d;
  logic [AccW-1:0]    m_energy_q, m_energy_d;
  logic [BinNumW-1:0] m_bin_q, m_bin_d;

  logic [AccW-1:0]    mem [NUM_BINS];
  logic [AccW-1:0]    rd_data_q;
  logic               mem_we;
  logic [BinW-1:0]    mem_waddr;
  logic [AccW-1:0]    mem_wdata;

  tbeh_pkg::div_req_t div_req;
  tbeh_pkg::div_rsp_t div_rsp;

  logic [TimeW:0]     diff;
  logic [AccW:0]      sum;
  logic [AccW-1:0]    sat_sum;
  logic               in_xfer;
  logic               out_free;

  assign diff = {s_axis_tdata[TimeW-1], s_axis_tdata[TimeW-1:0]}
              - {time_start_q[TimeW-1], time_start_q};
  assign sum     = {1'b0, rd_data_q} + (AccW+1)'(energy_q);
  assign sat_sum = sum[AccW] ? {AccW{1'b1}} : sum[AccW-1:0];

  assign s_axis_tready = (state_q == tbeh_pkg::ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d          = state_q;
    cmd_d            = cmd_q;
    clr_addr_d       = clr_addr_q;
    bin_d            = bin_q;
    energy_d         = energy_q;
    m_valid_d        = m_valid_q && !m_axis_tready;
    m_energy_d       = m_energy_q;
    m_bin_d          = m_bin_q;
    mem_we           = 1'b0;
    mem_waddr        = bin_q;
    mem_wdata        = sat_sum;
    div_req.start    = 1'b0;
    div_req.dividend = diff[TimeW-1:0];
    div_req.divisor  = (bin_step_q == '0) ? StepW'(1) : bin_step_q;
    case (state_q)
      tbeh_pkg::ST_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_addr_q;
        mem_wdata  = '0;
        clr_addr_d = clr_addr_q + BinW'(1);
        if (clr_addr_q == LastBin) begin
          state_d = tbeh_pkg::ST_IDLE;
        end
      end
      tbeh_pkg::ST_IDLE: begin
        if (in_xfer) begin
          cmd_d    = tbeh_pkg::cmd_e'(s_axis_tuser);
          energy_d = s_axis_tdata[TimeW +: EnergyW];
          case (tbeh_pkg::cmd_e'(s_axis_tuser))
            tbeh_pkg::CMD_ADD, tbeh_pkg::CMD_QUERY: begin
              if (diff[TimeW]) begin
                bin_d   = '0;
                state_d = tbeh_pkg::ST_READ;
              end else begin
                div_req.start = 1'b1;
                state_d       = tbeh_pkg::ST_DIV;
              end
            end
            tbeh_pkg::CMD_CLEAR: begin
              clr_addr_d = '0;
              state_d    = tbeh_pkg::ST_CLEAR;
            end
            default: begin
              state_d = tbeh_pkg::ST_IDLE;
            end
          endcase
        end
      end
      tbeh_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient > TimeW'(NUM_BINS - 1)) begin
            bin_d = LastBin;
          end else begin
            bin_d = div_rsp.quotient[BinW-1:0];
          end
          state_d = tbeh_pkg::ST_READ;
        end
      end
      tbeh_pkg::ST_READ: begin
        state_d = tbeh_pkg::ST_UPDATE;
      end
      tbeh_pkg::ST_UPDATE: begin
        if (cmd_q == tbeh_pkg::CMD_ADD) begin
          mem_we  = 1'b1;
          state_d = tbeh_pkg::ST_IDLE;
        end else if (out_free) begin
          m_valid_d  = 1'b1;
          m_energy_d = rd_data_q;
          m_bin_d    = BinNumW'(bin_q);
          state_d    = tbeh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tbeh_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tbeh_pkg::ST_CLEAR;
      clr_addr_q   <= '0;
      m_valid_q    <= 1'b0;
      time_start_q <= tbeh_pkg::TimeStartRst;
      bin_step_q   <= tbeh_pkg::BinStepRst;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      m_valid_q  <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (tbeh_pkg::cfg_idx_e'(cfg_index_i))
          tbeh_pkg::CFG_TIME_START: time_start_q <= cfg_data_i;
          tbeh_pkg::CFG_BIN_STEP:   bin_step_q   <= cfg_data_i[StepW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    bin_q      <= bin_d;
    energy_q   <= energy_d;
    m_energy_q <= m_energy_d;
    m_bin_q    <= m_bin_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[bin_q];
  end

  tbeh_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(tbeh_pkg::OutDataW - BinNumW - AccW)'(0), m_bin_q, m_energy_q};

endmodule

FILE: design/tbeh_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Divides the unsigned time offset by the bin step; uses tbeh_pkg.
// The dividend register shifts out dividend bits and shifts in quotient bits.
module tbeh_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tbeh_pkg::div_req_t req_i,
  output tbeh_pkg::div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(tbeh_pkg::TimeW);

  logic [tbeh_pkg::TimeW-1:0] dvd_q, dvd_d;
  logic [tbeh_pkg::StepW-1:0] dvs_q, dvs_d;
  logic [tbeh_pkg::StepW-1:0] rem_q, rem_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;

  logic [tbeh_pkg::StepW:0]   rem_shift;
  logic [tbeh_pkg::StepW:0]   trial;
  logic                       qbit;

  assign rem_shift = {rem_q, dvd_q[tbeh_pkg::TimeW-1]};
  assign trial     = rem_shift - {1'b0, dvs_q};
  assign qbit      = ~trial[tbeh_pkg::StepW];

  always_comb begin
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[tbeh_pkg::TimeW-2:0], qbit};
      rem_d = qbit ? trial[tbeh_pkg::StepW-1:0] : rem_shift[tbeh_pkg::StepW-1:0];
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(tbeh_pkg::TimeW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

FILE: design/tbeh_checker.sv
// Port-level checker for the time-binned energy histogram unit.
// Uses tbeh_pkg; bound to time_binned_energy_histogram_unit at the end of this file.
module tbeh_checker #(
  parameter int unsigned NUM_BINS = tbeh_pkg::NumBinsDef
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [tbeh_pkg::InDataW-1:0]  s_axis_tdata,
  input logic [tbeh_pkg::CmdW-1:0]     s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [tbeh_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [tbeh_pkg::CfgIdxW-1:0]  cfg_index_i,
  input logic [tbeh_pkg::TimeW-1:0]    cfg_data_i
);

  logic cmd_known;

  assign cmd_known = (s_axis_tuser == tbeh_pkg::CMD_ADD)
                  || (s_axis_tuser == tbeh_pkg::CMD_QUERY)
                  || (s_axis_tuser == tbeh_pkg::CMD_CLEAR);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_bin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(m_axis_tdata[48:40]) <= NUM_BINS - 1)
      || (NUM_BINS > 512))
    else $error("bin number out of range");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[tbeh_pkg::OutDataW-1:49] == '0)
    else $error("padding bits not zero");

  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && cmd_known |=> !s_axis_tready)
    else $error("input taken again right after a command");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration transfer refused");

endmodule

bind time_binned_energy_histogram_unit tbeh_checker #(.NUM_BINS(NUM_BINS)) u_checker (.*);

FILE: tb/histogram_checker.sv
// Checker for the time-binned energy histogram unit: watches the input, result and
// register channels, keeps its own copy of the bins and compares every readout.
// Depends on tbeh_pkg for widths, command codes and register indexes.
module histogram_checker #(
  parameter int unsigned NUM_BINS = tbeh_pkg::NumBinsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [tbeh_pkg::InDataW-1:0]  in_data_i,
  input  logic [tbeh_pkg::CmdW-1:0]     in_user_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [tbeh_pkg::OutDataW-1:0] out_data_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [tbeh_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tbeh_pkg::TimeW-1:0]    cfg_data_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import tbeh_pkg::*;

  localparam int unsigned ReportLimit = 60;

  typedef struct packed {
    logic [AccW-1:0]    energy_sum;
    logic [BinNumW-1:0] bin;
  } readout_t;

  logic [AccW-1:0]  bin_totals [NUM_BINS];
  logic [TimeW-1:0] time_start;
  logic [StepW-1:0] bin_step;
  readout_t         expected_readouts [$];
  readout_t         want;
  readout_t         got;
  int unsigned      slot;
  logic [AccW:0]    total;
  logic [TimeW-1:0] stamp;
  logic [EnergyW-1:0] deposit;

  function automatic int unsigned clamped_bin(input logic [TimeW-1:0] hit_time);
    longint offset;
    longint width;
    longint quotient;
    offset = longint'(signed'(hit_time)) - longint'(signed'(time_start));
    width = (bin_step == '0) ? 64'sd1 : longint'({48'd0, bin_step});
    if (offset < 0) begin
      return 0;
    end
    quotient = offset / width;
    if (quotient > longint'(NUM_BINS - 1)) begin
      return NUM_BINS - 1;
    end
    return int'(quotient);
  endfunction

  function automatic void report(input string what, input longint unsigned exp_val,
                                 input longint unsigned act_val);
    if (fail_count_o < ReportLimit) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_val, act_val);
    end
    fail_count_o++;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      foreach (bin_totals[i]) bin_totals[i] = '0;
      time_start = TimeStartRst;
      bin_step = BinStepRst;
      expected_readouts.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.energy_sum = out_data_i[AccW-1:0];
        got.bin = out_data_i[AccW +: BinNumW];
        if (expected_readouts.size() == 0) begin
          if (fail_count_o < ReportLimit) begin
            $display("%0t: unexpected readout, expected none, actual bin %0d energy %0d",
                     $time, got.bin, got.energy_sum);
          end
          fail_count_o++;
        end else begin
          want = expected_readouts.pop_front();
          if (got.energy_sum !== want.energy_sum) begin
            report("bin_energy", want.energy_sum, got.energy_sum);
          end
          if (got.bin !== want.bin) begin
            report("bin_number", want.bin, got.bin);
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        stamp = in_data_i[TimeW-1:0];
        deposit = in_data_i[TimeW +: EnergyW];
        case (in_user_i)
          CMD_ADD: begin
            slot = clamped_bin(stamp);
            total = {1'b0, bin_totals[slot]} + (AccW + 1)'(deposit);
            bin_totals[slot] = total[AccW] ? '1 : total[AccW-1:0];
          end
          CMD_QUERY: begin
            slot = clamped_bin(stamp);
            want.energy_sum = bin_totals[slot];
            want.bin = BinNumW'(slot);
            expected_readouts.push_back(want);
          end
          CMD_CLEAR: begin
            foreach (bin_totals[i]) bin_totals[i] = '0;
          end
          default: begin
          end
        endcase
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_TIME_START: time_start = cfg_data_i;
          CFG_BIN_STEP:   bin_step = cfg_data_i[StepW-1:0];
          default: begin
          end
        endcase
      end

      pending_o <= expected_readouts.size();
    end
  end

endmodule

FILE: tb/testbench.sv
// Top of the histogram unit testbench: clock, reset, stimulus with random idling and
// the verdict. Instantiates time_binned_energy_histogram_unit and histogram_checker,
// and takes widths and codes from tbeh_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tbeh_pkg::*;

  localparam int unsigned NumBins      = NumBinsDef;
  localparam int unsigned CycleLimit   = 4_000_000;
  localparam int unsigned QuietCycles  = 500;
  localparam int unsigned IdlePercent  = 18;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned FillAdds     = 60;
  localparam int unsigned RandomPhases = 6;
  localparam int unsigned PhaseItems   = 110;

  localparam logic [CmdW-1:0]    CmdUnused = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata;
  logic [CmdW-1:0]       s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i;
  logic [TimeW-1:0]      cfg_data_i;

  int unsigned fail_count;
  int unsigned pending_readouts;
  int unsigned cycle_count = 0;
  logic        calm = 1'b0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  time_binned_energy_histogram_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  histogram_checker histogram_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_user_i    (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending_readouts)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= IdlePercent);
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic send_item(input logic [CmdW-1:0] command, input logic [TimeW-1:0] stamp,
                           input logic [EnergyW-1:0] deposit);
    while (!calm && $urandom_range(99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= command;
    s_axis_tdata <= {deposit, stamp};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [TimeW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic program_window(input logic [TimeW-1:0] origin, input logic [TimeW-1:0] step_word,
                                input bit poke_unused);
    write_reg(CFG_TIME_START, origin);
    write_reg(CFG_BIN_STEP, step_word);
    if (poke_unused) begin
      write_reg(CfgUnused, $urandom);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_readouts != 0) @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  function automatic logic [TimeW-1:0] pick_stamp(input logic [TimeW-1:0] origin,
                                                  input int unsigned width);
    int unsigned span;
    int unsigned roll;
    span = NumBins * width;
    roll = $urandom_range(99);
    if (roll < 70) begin
      return origin - width + $urandom_range(span + 2 * width);
    end else if (roll < 85) begin
      return $urandom;
    end
    case ($urandom_range(5))
      0: return origin - 1;
      1: return origin;
      2: return origin + 1;
      3: return origin + span - 1;
      4: return origin + span;
      default: return origin + span + 1;
    endcase
  endfunction

  function automatic logic [EnergyW-1:0] pick_energy();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) begin
      return '1;
    end else if (roll < 15) begin
      return '0;
    end
    return EnergyW'($urandom);
  endfunction

  function automatic logic [CmdW-1:0] pick_command();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) begin
      return CMD_ADD;
    end else if (roll < 92) begin
      return CMD_QUERY;
    end else if (roll < 96) begin
      return CMD_CLEAR;
    end
    return CmdUnused;
  endfunction

  initial begin
    int unsigned phase;
    logic [TimeW-1:0] origin;
    int unsigned width;

    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset window: bin 0 starts at 1000 and each bin is 10 wide.
    send_item(CMD_QUERY, 32'd1000, '0);
    send_item(CMD_ADD, 32'd1050, '1);
    send_item(CMD_ADD, 32'd1059, 24'd7);
    send_item(CMD_QUERY, 32'd1055, '0);
    send_item(CMD_ADD, 32'h8000_0000, 24'd123);
    send_item(CMD_ADD, 32'd999, 24'd1);
    send_item(CMD_QUERY, 32'd1000, '0);
    send_item(CMD_ADD, 32'd4999, 24'd11);
    send_item(CMD_ADD, 32'd5000, 24'd13);
    send_item(CMD_ADD, 32'h7FFF_FFFF, 24'd17);
    send_item(CMD_QUERY, 32'd4990, '0);
    send_item(CmdUnused, 32'd1050, 24'h00FFFF);
    send_item(CMD_QUERY, 32'd1050, '0);
    send_item(CMD_CLEAR, 32'hFFFF_FFFF, '1);
    send_item(CMD_QUERY, 32'd1050, '0);
    send_item(CMD_QUERY, 32'h7FFF_FFFF, '0);
    wait_quiet();

    // A step of zero acts as a step of one; the window starts at the most negative time.
    program_window(32'h8000_0000, 32'hFFFF_0000, 1'b1);
    send_item(CMD_ADD, 32'h8000_018E, 24'h800000);
    send_item(CMD_QUERY, 32'h8000_018E, '0);
    send_item(CMD_ADD, 32'h7FFF_FFFF, 24'h000001);
    send_item(CMD_QUERY, 32'h7FFF_FFFF, '0);
    wait_quiet();

    program_window(32'h7FFF_FFFF, 32'h0000_FFFF, 1'b0);
    send_item(CMD_ADD, 32'h8000_0000, 24'h5A5A5A);
    send_item(CMD_QUERY, 32'h7FFF_FFFF, '0);
    wait_quiet();

    // Underflow hits skip the divider and pile up in bin 0 back to back.
    program_window(32'd0, 32'd10, 1'b0);
    calm <= 1'b1;
    repeat (FillAdds) send_item(CMD_ADD, {1'b1, 31'($urandom)}, '1);
    send_item(CMD_QUERY, {1'b1, 31'($urandom)}, '0);
    calm <= 1'b0;
    wait_quiet();

    for (phase = 0; phase < RandomPhases; phase++) begin
      if (phase == 4) begin
        origin = 32'h7FFF_FF00;
      end else if (phase % 2 == 0) begin
        origin = TimeW'($urandom_range(5000));
      end else begin
        origin = $urandom;
      end
      if (phase == 1) begin
        width = 1;
      end else if (phase == 2) begin
        width = 65535;
      end else begin
        width = $urandom_range(64, 1);
      end
      program_window(origin, {16'($urandom), 16'(width)}, phase == 0);
      calm <= (phase == 3);
      hold_req <= (phase == 5);
      repeat (PhaseItems) send_item(pick_command(), pick_stamp(origin, width), pick_energy());
      wait_quiet();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/tbeh_pkg.sv
design/tbeh_div.sv
design/time_binned_energy_histogram_unit.sv
design/tbeh_checker.sv
tb/histogram_checker.sv
tb/testbench.sv
